// ===== rtl/palindromic_tree_builder_core_macros.svh =====
// ----------------------------------------------------------------------------
// palindromic tree builder assertion macros
// shared property wrappers for the checker, clocked on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef PALINDROMIC_TREE_BUILDER_CORE_MACROS_SVH
`define PALINDROMIC_TREE_BUILDER_CORE_MACROS_SVH

// plain property under clock and reset
`define PTB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ptb assertion failed");

// same-cycle implication
`define PTB_ASSERT_IMP(lbl, ante, cons) `PTB_ASSERT(lbl, (ante) |-> (cons))

// next-cycle implication
`define PTB_ASSERT_NXT(lbl, ante, cons) `PTB_ASSERT(lbl, (ante) |=> (cons))

`endif

// ===== rtl/ptb_pkg.sv =====
// ----------------------------------------------------------------------------
// ptb_pkg
// types, defaults and state codes shared by the palindromic tree builder
// ----------------------------------------------------------------------------
`default_nettype none

package ptb_pkg;

    localparam int MAX_LEN_DEF  = 1024;
    localparam int ALPHABET_DEF = 26;

    typedef struct packed {
        logic [4:0] letter;
        logic       start_new;
    } t_in_item;

    typedef struct packed {
        logic [9:0]  position;
        logic        created;
        logic [9:0]  pal_start;
        logic [10:0] pal_length;
        logic [10:0] suffix_pal_length;
        logic [10:0] distinct_count;
        logic        overflow;
    } t_out_item;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_READ,
        S_JUMP,
        S_CMP,
        S_FOUND,
        S_PAR,
        S_DECIDE,
        S_CURLEN,
        S_SLEN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic init_walk;
        logic overflow_res;
        logic rd_node;
        logic test_text;
        logic follow;
        logic found;
        logic rd_edge;
        logic rd_par;
        logic reuse;
        logic create;
        logic link_one;
        logic start_link;
        logic link_set;
        logic rd_cur;
        logic cap_slen;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic full;
        logic node_zero;
        logic j_neg;
        logic txt_match;
        logic edge_ok;
        logic room;
        logic len_one;
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/ptb_if.sv =====
// ----------------------------------------------------------------------------
// ptb_if
// valid/ready channels for letter requests and result requests
// ----------------------------------------------------------------------------
`default_nettype none

interface ptb_in_if import ptb_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ptb_out_if import ptb_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ptb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptb_ctrl
// sequencer for the suffix link walks, edge lookup and node creation
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_ctrl import ptb_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        case (r_state)
            S_CLEAR:  if (i_sts.clr_done) n_state = S_IDLE;
            S_IDLE:   if (i_in_valid) n_state = S_CHECK;
            S_CHECK: begin
                n_phase = 1'b0;
                n_state = i_sts.full ? S_EMIT : S_READ;
            end
            S_READ:   n_state = S_JUMP;
            S_JUMP: begin
                if (i_sts.node_zero) n_state = S_FOUND;
                else if (i_sts.j_neg) n_state = S_READ;
                else n_state = S_CMP;
            end
            S_CMP:    n_state = i_sts.txt_match ? S_FOUND : S_READ;
            S_FOUND:  n_state = S_PAR;
            S_PAR:    n_state = S_DECIDE;
            S_DECIDE: begin
                if (r_phase) n_state = S_EMIT;
                else if (i_sts.edge_ok) n_state = S_CURLEN;
                else if (!i_sts.room) n_state = S_CURLEN;
                else if (i_sts.len_one) n_state = S_EMIT;
                else begin
                    n_state = S_READ;
                    n_phase = 1'b1;
                end
            end
            S_CURLEN: n_state = S_SLEN;
            S_SLEN:   n_state = S_EMIT;
            S_EMIT:   if (!i_sts.out_busy) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR:  o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_CHECK: begin
                o_cmd.overflow_res = i_sts.full;
                o_cmd.init_walk    = !i_sts.full;
            end
            S_READ:   o_cmd.rd_node = 1'b1;
            S_JUMP: begin
                if (!i_sts.node_zero) begin
                    o_cmd.follow    = i_sts.j_neg;
                    o_cmd.test_text = !i_sts.j_neg;
                end
            end
            S_CMP:    o_cmd.follow = !i_sts.txt_match;
            S_FOUND: begin
                o_cmd.found   = !r_phase;
                o_cmd.rd_edge = 1'b1;
            end
            S_PAR:    o_cmd.rd_par = 1'b1;
            S_DECIDE: begin
                if (r_phase) o_cmd.link_set = 1'b1;
                else if (i_sts.edge_ok) o_cmd.reuse = 1'b1;
                else if (i_sts.room) begin
                    o_cmd.create     = 1'b1;
                    o_cmd.link_one   = i_sts.len_one;
                    o_cmd.start_link = !i_sts.len_one;
                end
            end
            S_CURLEN: o_cmd.rd_cur = 1'b1;
            S_SLEN:   o_cmd.cap_slen = 1'b1;
            S_EMIT:   o_cmd.emit = !i_sts.out_busy;
            default:  o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ptb_datapath.sv =====
// ----------------------------------------------------------------------------
// ptb_datapath
// text, node and edge memories, walk registers and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_datapath import ptb_pkg::*; #(
    parameter int MAX_LEN  = MAX_LEN_DEF,
    parameter int ALPHABET = ALPHABET_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_in_data,
    input  wire       i_out_ready,
    output t_sts      o_sts,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    localparam int NODES = MAX_LEN + 2;
    localparam int EDGES = NODES * ALPHABET;
    localparam int NW    = $clog2(NODES);
    localparam int EW    = $clog2(EDGES);
    localparam int CW    = $clog2(ALPHABET);
    localparam int PW    = $clog2(MAX_LEN + 1);
    localparam int TW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW    = $clog2(MAX_LEN + 3) + 1;
    localparam int JW    = ((PW > LW) ? PW : LW) + 2;

    logic [CW-1:0] text_mem [MAX_LEN];
    logic [LW-1:0] len_mem  [NODES];
    logic [NW-1:0] link_mem [NODES];
    logic [NW-1:0] par_mem  [NODES];
    logic [CW-1:0] chr_mem  [NODES];
    logic [NW-1:0] edge_mem [EDGES];

    logic [CW-1:0] r_ch;
    logic [PW-1:0] r_pos;
    logic [NW-1:0] r_cur, r_total, r_node, r_ptr, r_ptr_link, r_new;
    logic [LW-1:0] r_len_q, r_ptr_len;
    logic [NW-1:0] r_link_q, r_edge_q, r_par_q;
    logic [CW-1:0] r_txt_q, r_chr_q;
    logic [EW-1:0] r_clr;
    t_out_item     r_work, r_out;
    logic          r_out_valid;

    logic signed [LW-1:0] len_node, len_cur, new_len;
    logic [NW-1:0]        link_node, n_id, par_idx, len_addr;
    logic [JW-1:0]        j;
    logic [EW-1:0]        edge_addr;
    logic                 edge_ok;
    t_out_item            res_item;

    assign len_node  = (r_node == '0) ? '1 : ((r_node == NW'(1)) ? '0 : r_len_q);
    assign len_cur   = (r_cur == '0) ? '1 : ((r_cur == NW'(1)) ? '0 : r_len_q);
    assign link_node = (r_node < NW'(2)) ? '0 : r_link_q;
    assign new_len   = r_ptr_len + LW'(2);
    assign n_id      = r_total + NW'(1);
    assign j         = JW'({1'b0, r_pos}) - JW'(len_node) - JW'(1);
    assign edge_addr = EW'(EW'(r_node) * EW'(ALPHABET) + EW'(r_ch));
    assign par_idx   = (32'(r_edge_q) < NODES) ? r_edge_q : '0;
    assign len_addr  = i_cmd.rd_cur ? r_cur : r_node;
    assign edge_ok   = (r_edge_q >= NW'(2)) && (r_edge_q <= r_total)
                    && (r_par_q == r_node) && (r_chr_q == r_ch);

    assign o_sts.clr_done  = (r_clr == EW'(EDGES - 1));
    assign o_sts.full      = (32'(r_pos) >= MAX_LEN);
    assign o_sts.node_zero = (r_node == '0);
    assign o_sts.j_neg     = j[JW-1];
    assign o_sts.txt_match = (r_txt_q == r_ch);
    assign o_sts.edge_ok   = edge_ok;
    assign o_sts.room      = (32'(r_total) + 1 < NODES);
    assign o_sts.len_one   = (new_len == LW'(1));
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        res_item                = r_work;
        res_item.distinct_count = 11'(r_total - NW'(1));
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_walk) text_mem[r_pos[TW-1:0]] <= r_ch;
        if (i_cmd.test_text) r_txt_q <= text_mem[j[TW-1:0]];
        if (i_cmd.rd_node || i_cmd.rd_cur) begin
            r_len_q  <= len_mem[len_addr];
            r_link_q <= link_mem[len_addr];
        end
        if (i_cmd.create) begin
            len_mem[n_id] <= new_len;
            par_mem[n_id] <= r_ptr;
            chr_mem[n_id] <= r_ch;
        end
        if (i_cmd.link_one) link_mem[n_id] <= NW'(1);
        else if (i_cmd.link_set) link_mem[r_new] <= edge_ok ? r_edge_q : '0;
        if (i_cmd.rd_par) begin
            r_par_q <= par_mem[par_idx];
            r_chr_q <= chr_mem[par_idx];
        end
        if (i_cmd.clr_step) edge_mem[r_clr] <= '0;
        else if (i_cmd.create) edge_mem[edge_addr] <= n_id;
        if (i_cmd.rd_edge) r_edge_q <= edge_mem[edge_addr];
    end

    // walk and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_pos       <= '0;
            r_cur       <= NW'(1);
            r_total     <= NW'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + EW'(1);
            if (i_cmd.accept) begin
                r_ch <= (32'(i_in_data.letter) >= ALPHABET) ? CW'(ALPHABET - 1)
                                                             : CW'(i_in_data.letter);
                r_work <= '0;
                if (i_in_data.start_new) begin
                    r_pos   <= '0;
                    r_cur   <= NW'(1);
                    r_total <= NW'(1);
                end
            end
            if (i_cmd.overflow_res) r_work.overflow <= 1'b1;
            if (i_cmd.init_walk) begin
                r_node          <= r_cur;
                r_work.position <= 10'(r_pos);
            end
            if (i_cmd.follow) r_node <= link_node;
            if (i_cmd.found) begin
                r_ptr      <= r_node;
                r_ptr_len  <= len_node;
                r_ptr_link <= link_node;
            end
            if (i_cmd.reuse) r_cur <= r_edge_q;
            if (i_cmd.create) begin
                r_total                  <= n_id;
                r_new                    <= n_id;
                r_cur                    <= n_id;
                r_work.created           <= 1'b1;
                r_work.pal_length        <= 11'(new_len);
                r_work.suffix_pal_length <= 11'(new_len);
                r_work.pal_start         <= 10'(r_pos + PW'(1) - PW'(new_len));
            end
            if (i_cmd.start_link) r_node <= r_ptr_link;
            if (i_cmd.cap_slen) r_work.suffix_pal_length <= 11'(len_cur);
            if (i_cmd.emit) begin
                r_out       <= res_item;
                r_out_valid <= 1'b1;
                if (!r_work.overflow) r_pos <= r_pos + PW'(1);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/palindromic_tree_builder_core.sv =====
// ----------------------------------------------------------------------------
// palindromic_tree_builder_core
// builds an eertree of the palindromes in a letter stream, one result a letter
//
//   channel   dir   payload                                   handshake
//   i_in      in    letter, start_new                         valid/ready
//   o_res     out   position, created, pal_start, pal_length, valid/ready
//                   suffix_pal_length, distinct_count, overflow
//
// a letter walks the suffix links until a node extends, then reuses the node on
// that edge or, room permitting, creates one, which may need its own link walk;
// a dropped letter skips the walks; each node tried is one node memory read,
// then, unless it starts before the text, one text memory read and compare
// after reset the edge memory is swept, (MAX_LEN+2)*ALPHABET entries with ready low
// reset is synchronous; the next letter is taken while a result still waits,
// and a finished letter stalls until the previous result is taken
// ----------------------------------------------------------------------------
`default_nettype none

module palindromic_tree_builder_core import ptb_pkg::*; #(
    parameter int MAX_LEN  = MAX_LEN_DEF,
    parameter int ALPHABET = ALPHABET_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ptb_in_if.sink      i_in,
    ptb_out_if.source   o_res
);

    t_cmd cmd;
    t_sts sts;

    ptb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    ptb_datapath #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in.data),
        .i_out_ready (o_res.ready),
        .o_sts       (sts),
        .o_out_valid (o_res.valid),
        .o_out_data  (o_res.data)
    );

endmodule

`default_nettype wire

// ===== rtl/ptb_checker.sv =====
// ----------------------------------------------------------------------------
// ptb_checker
// port-level checks on the result stream of the palindromic tree builder
// ----------------------------------------------------------------------------
`default_nettype none

`include "palindromic_tree_builder_core_macros.svh"

module ptb_checker import ptb_pkg::*; (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input t_out_item i_out_data
);

    `PTB_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))
    `PTB_ASSERT_IMP(a_ovf_clean, i_out_valid && i_out_data.overflow, !i_out_data.created && i_out_data.position == 10'd0 && i_out_data.pal_length == 11'd0 && i_out_data.suffix_pal_length == 11'd0)
    `PTB_ASSERT_IMP(a_new_is_suffix, i_out_valid && i_out_data.created, i_out_data.pal_length == i_out_data.suffix_pal_length && i_out_data.pal_length != 11'd0)
    `PTB_ASSERT_IMP(a_suffix_fits, i_out_valid && !i_out_data.overflow, i_out_data.suffix_pal_length <= 11'(i_out_data.position) + 11'd1)

endmodule

bind palindromic_tree_builder_core ptb_checker u_ptb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

`default_nettype wire

// ===== tb/palindromic_tree_builder_core_tb.sv =====
// ----------------------------------------------------------------------------
// palindromic_tree_builder_core_tb
// drives letter requests into the eertree builder and checks every result
// request against an in-bench palindromic tree, with idle and stall phases
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module palindromic_tree_builder_core_tb;
    import ptb_pkg::*;

    localparam int STR_CAP = MAX_LEN_DEF;
    localparam int ABC     = ALPHABET_DEF;
    localparam int NODE_CAP = STR_CAP + 2;

    logic i_clk;
    logic i_rst_n;

    ptb_in_if  letter_ch ();
    ptb_out_if res_ch ();

    palindromic_tree_builder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (letter_ch),
        .o_res   (res_ch)
    );

    // tree mirror
    logic [4:0] txt [STR_CAP];
    int         pal_len [NODE_CAP];
    int         sfx_link [NODE_CAP];
    int         end_pos [NODE_CAP];
    int         kids [NODE_CAP][ABC];
    int         cur_node;
    int         node_cnt;
    int         str_pos;

    t_out_item  pending_res [$];
    int         src_idle_pct;
    int         snk_stall_pct;
    int         n_letters;
    int         n_results;
    int         n_new_pals;
    int         n_dropped;
    int         n_errors;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("timeout at %0t", $time);
        $display("TB_ERROR");
        $finish;
    end

    function automatic void wipe_tree();
        for (int n = 0; n < NODE_CAP; n++) begin
            for (int c = 0; c < ABC; c++) kids[n][c] = 0;
        end
        pal_len[0] = -1;
        sfx_link[0] = 0;
        pal_len[1] = 0;
        sfx_link[1] = 0;
        cur_node = 1;
        node_cnt = 1;
        str_pos = 0;
    endfunction

    function automatic int find_extendable(int node, int p, int ch);
        int j;
        while (node != 0) begin
            j = p - pal_len[node] - 1;
            if (j >= 0 && int'(txt[j]) == ch) break;
            node = sfx_link[node];
        end
        return node;
    endfunction

    function automatic t_out_item append_letter(logic [4:0] letter, logic start_new);
        t_out_item r;
        int ch;
        int ptr;
        int n;
        int q;
        r = '0;
        ch = (letter >= ABC) ? ABC - 1 : int'(letter);
        if (start_new) wipe_tree();
        if (str_pos >= STR_CAP) begin
            r.distinct_count = 11'(node_cnt - 1);
            r.overflow = 1'b1;
            return r;
        end
        txt[str_pos] = 5'(ch);
        ptr = find_extendable(cur_node, str_pos, ch);
        if (kids[ptr][ch] != 0) begin
            cur_node = kids[ptr][ch];
        end else begin
            node_cnt++;
            n = node_cnt;
            pal_len[n] = pal_len[ptr] + 2;
            end_pos[n] = str_pos;
            kids[ptr][ch] = n;
            if (pal_len[n] == 1) begin
                sfx_link[n] = 1;
            end else begin
                q = find_extendable(sfx_link[ptr], str_pos, ch);
                sfx_link[n] = kids[q][ch];
            end
            cur_node = n;
            r.created = 1'b1;
            r.pal_start = 10'(end_pos[n] + 1 - pal_len[n]);
            r.pal_length = 11'(pal_len[n]);
        end
        r.position = 10'(str_pos);
        r.suffix_pal_length = 11'(pal_len[cur_node]);
        r.distinct_count = 11'(node_cnt - 1);
        str_pos++;
        return r;
    endfunction

    task automatic send_letter(input logic [4:0] letter, input logic start_new);
        t_out_item e;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            letter_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        letter_ch.valid = 1'b1;
        letter_ch.data.letter = letter;
        letter_ch.data.start_new = start_new;
        do @(posedge i_clk); while (!letter_ch.ready);
        e = append_letter(letter, start_new);
        pending_res = {pending_res, e};
        n_letters++;
        if (e.created) n_new_pals++;
        if (e.overflow) n_dropped++;
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        @(negedge i_clk);
        letter_ch.valid = 1'b0;
        while (pending_res.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    task automatic check_field(input string fname, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $display("%0t mismatch %s expected %0d actual %0d", $time, fname, exp_v, got_v);
            n_errors++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_item e;
        t_out_item g;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            g = res_ch.data;
            if (pending_res.size() == 0) begin
                $display("%0t unexpected result %h", $time, g);
                n_errors++;
            end else begin
                e = pending_res.pop_front();
                check_field("position", e.position, g.position);
                check_field("created", e.created, g.created);
                check_field("pal_start", e.pal_start, g.pal_start);
                check_field("pal_length", e.pal_length, g.pal_length);
                check_field("suffix_pal_length", e.suffix_pal_length, g.suffix_pal_length);
                check_field("distinct_count", e.distinct_count, g.distinct_count);
                check_field("overflow", e.overflow, g.overflow);
                n_results++;
            end
        end
    end

    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) < snk_stall_pct) ? 1'b0 : 1'b1;
    end

    task automatic test_directed();
        logic [4:0] seq [] = '{5'd0, 5'd25, 5'd31, 5'd26, 5'd0, 5'd0, 5'd0, 5'd1, 5'd0,
                               5'd1, 5'd0, 5'd0, 5'd1};
        foreach (seq[i]) send_letter(seq[i], i == 0);
        send_letter(5'd2, 1'b1);
        send_letter(5'd2, 1'b0);
        send_letter(5'd3, 1'b0);
        send_letter(5'd2, 1'b0);
        send_letter(5'd2, 1'b0);
        send_letter(5'd16, 1'b1);
        send_letter(5'd8, 1'b0);
        send_letter(5'd16, 1'b0);
        drain_results();
    endtask

    // fill the string to capacity, push past it, then restart on the full string
    task automatic test_overflow();
        send_letter(5'd0, 1'b1);
        for (int i = 1; i < STR_CAP; i++) send_letter(5'($urandom_range(1)), 1'b0);
        send_letter(5'd0, 1'b0);
        send_letter(5'd31, 1'b0);
        send_letter(5'd1, 1'b1);
        send_letter(5'd1, 1'b0);
        drain_results();
    endtask

    task automatic test_random_strings(input int idle, input int stall, input int count,
                                       input bit hold_mid);
        int sent;
        int len;
        int abc_sz;
        logic [4:0] l;
        src_idle_pct = idle;
        snk_stall_pct = stall;
        sent = 0;
        while (sent < count) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(150, 300) : $urandom_range(30, 150);
            abc_sz = ($urandom_range(3) == 0) ? 26 : $urandom_range(2, 3);
            for (int i = 0; i < len && sent < count; i++) begin
                if ($urandom_range(19) == 0) l = 5'($urandom_range(31));
                else l = 5'($urandom_range(abc_sz - 1));
                send_letter(l, i == 0);
                sent++;
                if (hold_mid && sent == count / 2) drain_results();
            end
        end
        drain_results();
    endtask

    initial begin
        letter_ch.valid = 1'b0;
        letter_ch.data = '0;
        res_ch.ready = 1'b0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        n_letters = 0;
        n_results = 0;
        n_new_pals = 0;
        n_dropped = 0;
        n_errors = 0;
        wipe_tree();
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_overflow();
        test_random_strings(0, 0, 175, 1'b0);
        test_random_strings(45, 0, 175, 1'b1);
        test_random_strings(0, 45, 175, 1'b0);
        test_random_strings(27, 27, 175, 1'b0);

        src_idle_pct = 0;
        snk_stall_pct = 0;
        repeat (100) @(posedge i_clk);
        if (pending_res.size() != 0) begin
            $display("%0t %0d results never arrived", $time, pending_res.size());
            n_errors++;
        end
        $display("sent %0d letters, checked %0d results, %0d new palindromes, %0d dropped",
                 n_letters, n_results, n_new_pals, n_dropped);
        $display("idle and stall phases run, capacity overflow and restart exercised");
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/ptb_pkg.sv
rtl/ptb_if.sv
rtl/ptb_ctrl.sv
rtl/ptb_datapath.sv
rtl/palindromic_tree_builder_core.sv
rtl/ptb_checker.sv
tb/palindromic_tree_builder_core_tb.sv
